### hdl/caustic_intensity_grid_macros.svh
// Assertion macros for the caustic intensity grid.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef CAUSTIC_INTENSITY_GRID_MACROS_SVH
`define CAUSTIC_INTENSITY_GRID_MACROS_SVH
`ifndef SYNTHESIS
`define CIG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("caustic_intensity_grid check failed");
`define CIG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("caustic_intensity_grid check failed");
`else
`define CIG_ASSERT(lbl, clk, rst_n, prop)
`define CIG_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### hdl/cig_pkg.sv
// Shared constants, types and helpers of the caustic intensity grid.
// No dependencies; imported by cig_div and caustic_intensity_grid.
package cig_pkg;

  localparam int GridSize  = 32;               // power of two, 8 to 256
  localparam int IdxW      = $clog2(GridSize);
  localparam int CellW     = 2 * IdxW;
  localparam int HeightW   = 16;
  localparam int DepthW    = 16;
  localparam int OffW      = 24;
  localparam int LightW    = 17;
  localparam int SprW      = OffW + IdxW + 3;
  localparam int PrdW      = 2 * SprW;
  localparam int DivW      = 50;
  localparam int QuotW     = 17;
  localparam int RndShift  = 13 - IdxW;

  localparam logic [DepthW-1:0] DepthReset = 16'd16384;

  localparam logic [1:0] OpWrite   = 2'd0;
  localparam logic [1:0] OpCompute = 2'd1;
  localparam logic [1:0] OpRead    = 2'd2;

  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

  function automatic logic [IdxW-1:0] wrap_next(input logic [IdxW-1:0] i);
    return (i == IdxW'(GridSize - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] wrap_prev(input logic [IdxW-1:0] i);
    return (i == '0) ? IdxW'(GridSize - 1) : i - 1'b1;
  endfunction

endpackage

### hdl/caustic_intensity_grid.sv
// Top level of the caustic intensity grid: command port, APB register, memories.
// Depends on cig_pkg, cig_div and caustic_intensity_grid_macros.svh.
//
// Usage. An item is taken when start_i is high and busy_o is low; opcode_i
// selects write height (0), compute grid (1) or read cell (2); opcode 3 is
// dropped. A write stores height_value_i at (x_index_i, z_index_i) and gives
// no result. A read raises busy_o for one cycle and shows the cell's offsets
// and light level with valid_o in the cycle after the transfer. A compute
// walks the grid twice: an offset pass, then an intensity pass that waits
// for the divider at each cell unless the divisor is zero or huge (a
// saturating quotient is reported at once); the shared one-bit-per-cycle
// divider and the single read port of each memory set the length of a
// compute. Its result (valid_o and compute_done_o, all other fields zero)
// marks the end of busy_o. Results last one cycle; the receiver cannot
// stall. Reset clears the control state and sets water_depth to 1.0; the
// memories are not cleared, so cells hold no defined value until written
// or computed. water_depth sits at APB byte address 0 and may be written
// only while busy_o is low.
module caustic_intensity_grid import cig_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [1:0]                opcode_i,
  input  logic [IdxW-1:0]           x_index_i,
  input  logic [IdxW-1:0]           z_index_i,
  input  logic signed [HeightW-1:0] height_value_i,
  output logic                      valid_o,
  output logic                      compute_done_o,
  output logic signed [OffW-1:0]    offset_x_o,
  output logic signed [OffW-1:0]    offset_z_o,
  output logic signed [LightW-1:0]  light_level_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  `include "caustic_intensity_grid_macros.svh"

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StPass1 = 3'd2;
  localparam logic [2:0] StPass2 = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  localparam int TapHere = 0;
  localparam int TapXn   = 1;
  localparam int TapXp   = 2;
  localparam int TapZn   = 3;
  localparam int TapZp   = 4;
  localparam int Taps    = 5;
  localparam int WordW   = 2 * OffW;
  localparam int MemW    = WordW + LightW;
  localparam int MulW    = HeightW + 1 + HeightW + 2;

  localparam logic [3:0] StepMul1  = 4'd6;
  localparam logic [3:0] StepMul2  = 4'd7;
  localparam logic [3:0] StepWrite = 4'd8;
  localparam logic [3:0] StepWait  = 4'd9;

  localparam logic [PrdW-1:0]          ProdLimit = PrdW'(1) << 48;
  localparam logic signed [LightW:0]   LevelMax  = (LightW+1)'(32768);
  localparam logic signed [LightW-1:0] LevelLow  = -(LightW'(4096));

  // ---------------------------------------------------------------- control
  logic [2:0]       state_q, state_d;
  logic [3:0]       step_q;
  logic [CellW-1:0] cell_q;
  logic [DepthW-1:0] depth_q;
  logic             accept;
  logic [CellW-1:0] in_addr;
  logic [IdxW-1:0]  cx, cz;
  logic [CellW-1:0] nb_addr;
  logic             cell_end;

  assign accept  = start_i && !busy_o;
  assign in_addr = {x_index_i, z_index_i};
  assign cx      = cell_q[CellW-1:IdxW];
  assign cz      = cell_q[IdxW-1:0];
  assign busy_o  = state_q != StIdle;

  // neighbour walk: here, x next, x prev, z next, z prev
  always_comb begin
    case (step_q)
      4'd1:    nb_addr = {wrap_next(cx), cz};
      4'd2:    nb_addr = {wrap_prev(cx), cz};
      4'd3:    nb_addr = {cx, wrap_next(cz)};
      4'd4:    nb_addr = {cx, wrap_prev(cz)};
      default: nb_addr = cell_q;
    endcase
  end

  // ---------------------------------------------------------------- memories
  // heights in one memory; offsets and light level share the words of the other
  logic [HeightW-1:0] hmem [GridSize*GridSize];
  logic [MemW-1:0]    omem [GridSize*GridSize];
  logic [HeightW-1:0] h_rd_q;
  logic [MemW-1:0]    o_rd_q;
  logic               h_we, o_we, l_we;
  logic [CellW-1:0]   o_raddr;
  logic [WordW-1:0]   o_wdata;
  logic [LightW-1:0]  l_wdata;

  assign h_we    = accept && (opcode_i == OpWrite);
  assign o_raddr = (state_q == StPass2) ? nb_addr : in_addr;

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hmem[in_addr] <= height_value_i;
    end
    h_rd_q <= hmem[nb_addr];
  end

  always_ff @(posedge clk_i) begin
    if (o_we) begin
      omem[cell_q][MemW-1:LightW] <= o_wdata;
    end else if (l_we) begin
      omem[cell_q][LightW-1:0] <= l_wdata;
    end
    o_rd_q <= omem[o_raddr];
  end

  // ---------------------------------------------------------------- taps
  logic [WordW-1:0] tap_q [Taps];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Taps; k++) begin
      if (step_q == 4'(k + 1)) begin
        tap_q[k] <= (state_q == StPass1) ? WordW'(h_rd_q) : o_rd_q[MemW-1:LightW];
      end
    end
  end

  // ---------------------------------------------------------------- offset pass
  logic signed [HeightW-1:0] h_here, h_xn, h_xp, h_zn, h_zp;
  logic signed [HeightW:0]   diff_x, diff_z, mul_a;
  logic signed [HeightW+1:0] base;
  logic signed [MulW-1:0]    prod_q;
  logic signed [MulW-1:0]    rnd_sum;
  logic signed [MulW-1:0]    rnd;
  logic signed [OffW-1:0]    off_sat, offx_q;

  assign h_here = tap_q[TapHere][HeightW-1:0];
  assign h_xn   = tap_q[TapXn][HeightW-1:0];
  assign h_xp   = tap_q[TapXp][HeightW-1:0];
  assign h_zn   = tap_q[TapZn][HeightW-1:0];
  assign h_zp   = tap_q[TapZp][HeightW-1:0];
  assign diff_x = (HeightW+1)'(h_xn) - (HeightW+1)'(h_xp);
  assign diff_z = (HeightW+1)'(h_zn) - (HeightW+1)'(h_zp);
  assign base   = $signed({2'b00, depth_q}) + (HeightW+2)'(h_here);
  assign mul_a  = (step_q == StepMul1) ? diff_x : diff_z;

  // round half up, then saturate to the offset range
  assign rnd_sum = prod_q + MulW'(1 << (RndShift - 1));
  assign rnd     = rnd_sum >>> RndShift;
  always_comb begin
    if (rnd > MulW'(2**(OffW-1) - 1)) begin
      off_sat = {1'b0, {(OffW-1){1'b1}}};
    end else if (rnd < -(MulW'(2**(OffW-1)))) begin
      off_sat = {1'b1, {(OffW-1){1'b0}}};
    end else begin
      off_sat = rnd[OffW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_q == StepMul1 || step_q == StepMul2) begin
      if (state_q == StPass1) begin
        prod_q <= MulW'(mul_a * base);
      end
    end
    if (state_q == StPass1 && step_q == StepMul2) begin
      offx_q <= off_sat;
    end
  end

  assign o_wdata = {offx_q, off_sat};
  assign o_we    = (state_q == StPass1) && (step_q == StepWrite);

  // ---------------------------------------------------------------- intensity pass
  function automatic logic [SprW-1:0] spread(input logic signed [OffW-1:0] nxt,
                                             input logic signed [OffW-1:0] here,
                                             input logic signed [OffW-1:0] prv);
    logic signed [SprW-1:0] a;
    logic signed [SprW-1:0] b;
    logic [SprW-1:0]        abs_a;
    logic [SprW-1:0]        abs_b;
    a     = ((SprW'(nxt) - SprW'(here)) <<< IdxW) + SprW'(65536);
    b     = ((SprW'(here) - SprW'(prv)) <<< IdxW) + SprW'(65536);
    abs_a = a[SprW-1] ? SprW'(-a) : SprW'(a);
    abs_b = b[SprW-1] ? SprW'(-b) : SprW'(b);
    return abs_a + abs_b;
  endfunction

  logic [SprW-1:0]    sx_q, sz_q;
  logic [PrdW-1:0]    p_q;
  logic               div_start;
  logic [DivW-1:0]    div_num, div_den;
  div_stat_t          div_stat;
  logic [QuotW-1:0]   quot;
  logic signed [LightW:0] lvl;
  logic               zero_div, huge_div;

  always_ff @(posedge clk_i) begin
    if (state_q == StPass2 && step_q == StepMul1) begin
      sx_q <= spread(tap_q[TapXn][WordW-1:OffW], tap_q[TapHere][WordW-1:OffW],
                     tap_q[TapXp][WordW-1:OffW]);
      sz_q <= spread(tap_q[TapZn][OffW-1:0], tap_q[TapHere][OffW-1:0],
                     tap_q[TapZp][OffW-1:0]);
    end
    if (state_q == StPass2 && step_q == StepMul2) begin
      p_q <= sx_q * sz_q;
    end
  end

  assign zero_div  = (sx_q == '0) || (sz_q == '0);
  assign huge_div  = p_q > ProdLimit;
  assign div_start = (state_q == StPass2) && (step_q == StepWrite) && !zero_div && !huge_div;
  assign div_num   = DivW'(p_q) + (DivW'(1) << 48);
  assign div_den   = DivW'(p_q) << 1;

  cig_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quot_o  (quot)
  );

  assign lvl = $signed({1'b0, quot}) - (LightW+1)'(4096);

  always_comb begin
    l_we    = 1'b0;
    l_wdata = LightW'(LevelMax);
    if (state_q == StPass2 && step_q == StepWrite && zero_div) begin
      l_we = 1'b1;
    end else if (state_q == StPass2 && step_q == StepWrite && huge_div) begin
      l_we    = 1'b1;
      l_wdata = LevelLow;
    end else if (state_q == StPass2 && step_q == StepWait && div_stat.done) begin
      l_we = 1'b1;
      if (!div_stat.sat && lvl <= LevelMax) begin
        l_wdata = lvl[LightW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign cell_end = o_we || l_we;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept && opcode_i == OpRead) begin
          state_d = StRead;
        end else if (accept && opcode_i == OpCompute) begin
          state_d = StPass1;
        end
      end
      StRead:  state_d = StIdle;
      StPass1: begin
        if (cell_end && cell_q == '1) begin
          state_d = StPass2;
        end
      end
      StPass2: begin
        if (cell_end && cell_q == '1) begin
          state_d = StDone;
        end
      end
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      cell_q  <= '0;
      depth_q <= DepthReset;
    end else begin
      state_q <= state_d;
      if (state_q == StPass1 || state_q == StPass2) begin
        if (cell_end) begin
          step_q <= '0;
          cell_q <= cell_q + 1'b1;
        end else if (step_q != StepWait) begin
          step_q <= step_q + 1'b1;
        end
      end else begin
        step_q <= '0;
        cell_q <= '0;
      end
      if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
        depth_q <= pwdata[DepthW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- outputs
  assign valid_o        = (state_q == StRead) || (state_q == StDone);
  assign compute_done_o = state_q == StDone;
  assign offset_x_o     = (state_q == StRead) ? o_rd_q[MemW-1:LightW+OffW] : '0;
  assign offset_z_o     = (state_q == StRead) ? o_rd_q[LightW+OffW-1:LightW] : '0;
  assign light_level_o  = (state_q == StRead) ? o_rd_q[LightW-1:0] : '0;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(depth_q) : 32'd0;

  // ---------------------------------------------------------------- checks
  `CIG_ASSERT(a_valid_busy, clk_i, rst_ni, valid_o |-> busy_o)
  `CIG_ASSERT(a_done_zero, clk_i, rst_ni,
    compute_done_o |-> (offset_x_o == '0 && offset_z_o == '0 && light_level_o == '0))
  `CIG_ASSERT(a_div_pass2, clk_i, rst_ni, div_start |-> state_q == StPass2)
  `CIG_ASSERT(a_owe_pass1, clk_i, rst_ni, o_we |-> !l_we && state_q == StPass1)
  `CIG_ASSERT_ALWAYS(a_idle_no_result, clk_i, (state_q == StIdle) |-> !valid_o)

endmodule

### hdl/cig_div.sv
// Restoring divider, one quotient bit per cycle, saturating quotient.
// Depends on cig_pkg.
module cig_div import cig_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivW-1:0]  num_i,
  input  logic [DivW-1:0]  den_i,
  output div_stat_t        stat_o,
  output logic [QuotW-1:0] quot_o
);

  logic                     run_q;
  logic [$clog2(QuotW+1)-1:0] cnt_q;
  logic [DivW-1:0]          rem_q;
  logic [DivW-1:0]          den_q;
  logic [QuotW-1:0]         num_q;
  logic [QuotW-1:0]         quot_q;
  logic                     done_q;
  logic                     sat_q;
  logic [DivW:0]            trial;
  logic                     fits;

  assign trial = {rem_q, num_q[QuotW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !run_q) begin
        // quotient overflows its width: report saturation at once
        if (DivW'(num_i[DivW-1:QuotW]) >= den_i) begin
          done_q <= 1'b1;
          sat_q  <= 1'b1;
        end else begin
          sat_q <= 1'b0;
          run_q <= 1'b1;
          cnt_q <= ($clog2(QuotW+1))'(QuotW);
        end
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ($clog2(QuotW+1))'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !run_q) begin
      rem_q  <= DivW'(num_i[DivW-1:QuotW]);
      num_q  <= num_i[QuotW-1:0];
      den_q  <= den_i;
      quot_q <= '0;
    end else if (run_q) begin
      rem_q  <= fits ? DivW'(trial - {1'b0, den_q}) : trial[DivW-1:0];
      num_q  <= {num_q[QuotW-2:0], 1'b0};
      quot_q <= {quot_q[QuotW-2:0], fits};
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.sat  = sat_q;
  assign quot_o      = quot_q;

endmodule
